// File: design/lazy_two_opt_tour_flip_log_assert.svh
// Assertion macros for the lazy 2-opt tour block.
// Used by the port checker; needs clk_i and rst_ni in scope.
`ifndef LAZY_TWO_OPT_TOUR_FLIP_LOG_ASSERT_SVH
`define LAZY_TWO_OPT_TOUR_FLIP_LOG_ASSERT_SVH

// Checked on every clock edge outside reset
`define LZT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every clock edge, reset included
`define LZT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: design/lzt_pkg.sv
// Shared types, codes and defaults for the lazy 2-opt tour block.
// No dependencies.
package lzt_pkg;

  localparam int DEF_MAX_CITIES = 1024;
  localparam int DEF_LOG_DEPTH  = 64;

  // func codes of an input item
  localparam logic [2:0] FUNC_ADD    = 3'd0;
  localparam logic [2:0] FUNC_FLIP   = 3'd1;
  localparam logic [2:0] FUNC_REMOVE = 3'd2;
  localparam logic [2:0] FUNC_PERM   = 3'd3;
  localparam logic [2:0] FUNC_QUERY  = 3'd4;

  // result status codes
  localparam logic [1:0] STAT_DONE   = 2'd0;
  localparam logic [1:0] STAT_CANCEL = 2'd1;
  localparam logic [1:0] STAT_EMPTY  = 2'd2;

  typedef struct packed {
    logic [2:0]  func;
    logic [9:0]  city_a;
    logic [9:0]  city_b;
    logic [9:0]  city_c;
    logic [9:0]  city_d;
    logic [9:0]  query_slot;
    logic [23:0] cost_removed_one;
    logic [23:0] cost_removed_two;
    logic [23:0] cost_added_one;
    logic [23:0] cost_added_two;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] tour_length;
    logic [9:0]  city_at_slot;
    logic [9:0]  slot_of_city;
    logic [6:0]  pending_flips;
    logic [10:0] cities_placed;
  } out_item_t;

  // datapath micro-operations
  typedef enum logic [4:0] {
    OP_NONE, OP_ACCEPT, OP_ADD, OP_SLOT_RD, OP_MAP_FWD, OP_MAP_BWD, OP_MAP_RUN,
    OP_SAVE, OP_TOP_RD, OP_FLIP_END, OP_REM_EMPTY, OP_POP, OP_ORDER_RD,
    OP_QUERY_AT, OP_QUERY_OF, OP_C_LASTW, OP_C_ENT_RD, OP_C_ENTW, OP_C_SW0,
    OP_C_SW1, OP_C_SW2, OP_C_SW3, OP_C_SLINIT, OP_C_SLRD, OP_C_SLWR, OP_C_CLEAR,
    OP_RESP
  } dp_op_e;

  typedef enum logic [1:0] {CITY_A, CITY_B, CITY_C, CITY_D} city_sel_e;

  typedef struct packed {
    dp_op_e    op;
    city_sel_e city;
    logic      dst_pc;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic       cnt_zero;
    logic       cnt_full;
    logic       map_done;
    logic       pc_lt_pb;
    logic       k_eq_cnt;
    logic       i_lt_j;
    logic       lo_gt_hi;
    logic       i_eq_hi;
    logic       out_free;
  } dp_stat_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DISPATCH, ST_F_RD, ST_F_MAP, ST_F_RUN, ST_F_CHK, ST_F_TOP, ST_F_END,
    ST_REM_POP, ST_Q_MAPQ, ST_Q_RUNQ, ST_Q_AT, ST_Q_RDA, ST_Q_MAPA, ST_Q_RUNA,
    ST_C_LAST, ST_C_LASTW, ST_C_ENT, ST_C_ENTW, ST_C_SWCHK, ST_C_SW1, ST_C_SW2,
    ST_C_SW3, ST_C_SLINIT, ST_C_SLRD, ST_C_SLWR, ST_C_DONE, ST_RESP
  } ctrl_state_e;

endpackage

// File: design/lazy_two_opt_tour_flip_log.sv
// Lazy 2-opt tour top level, one item at a time; depends on lzt_pkg, lzt_ctrl, lzt_datapath.
// A flip whose range runs backwards is normalised via a and d. A commit (make_permanent
// or a full log before a flip) reverses each log entry by swapping city pairs, then
// rewrites the slots. The next item can be taken once the result is loaded, stalled or
// not. Reset clears counters, length and handshake; tables are not cleared.
module lazy_two_opt_tour_flip_log import lzt_pkg::*; #(
  parameter int MAX_CITIES = DEF_MAX_CITIES,
  parameter int LOG_DEPTH  = DEF_LOG_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_item_o,
  input  logic        cfg_we_i,
  input  logic [10:0] cfg_wdata_i
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  lzt_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .stat_i(stat), .cmd_o(cmd)
  );

  lzt_datapath #(.MAX_CITIES(MAX_CITIES), .LOG_DEPTH(LOG_DEPTH)) u_dp (
    .clk_i, .rst_ni, .in_item_i, .cmd_i(cmd), .stat_o(stat),
    .cfg_we_i, .cfg_wdata_i, .out_valid_o, .out_stall_i, .out_item_o
  );

endmodule

// File: design/lzt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lzt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/lzt_datapath.sv
// Datapath of the lazy 2-opt tour: tour tables, reversal log, counters, output register.
// Depends on lzt_pkg and lzt_ram; driven by micro-ops from lzt_ctrl.
module lzt_datapath import lzt_pkg::*; #(
  parameter int MAX_CITIES = DEF_MAX_CITIES,
  parameter int LOG_DEPTH  = DEF_LOG_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  in_item_t    in_item_i,
  input  dp_cmd_t     cmd_i,
  output dp_stat_t    stat_o,
  input  logic        cfg_we_i,
  input  logic [10:0] cfg_wdata_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_item_o
);

  localparam int CW   = $clog2(MAX_CITIES);
  localparam int NW   = CW + 1;
  localparam int LW   = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int CNTW = $clog2(LOG_DEPTH + 1);
  localparam int LEW  = 4 * CW + NW + 32;
  localparam int OFS_HIGH = 32;
  localparam int OFS_LOW  = 32 + CW;
  localparam int OFS_SUM  = 32 + 2 * CW;
  localparam int OFS_TO   = 32 + 2 * CW + NW;
  localparam int OFS_FROM = 32 + 3 * CW + NW;
  localparam int CC_RST   = (MAX_CITIES < 1024) ? MAX_CITIES : 1024;

  // reduce a 10-bit city number modulo MAX_CITIES, one compare-subtract per bit
  function automatic logic [CW-1:0] wrap_city(input logic [9:0] v);
    logic [31:0] r;
    logic [31:0] m;
    r = 32'(v);
    for (int k = 9; k >= 0; k--) begin
      m = 32'(MAX_CITIES) << k;
      if (r >= m) r = r - m;
    end
    return r[CW-1:0];
  endfunction

  // item registers
  logic [2:0]    func_q, func_d;
  logic [CW-1:0] a_q, a_d, b_q, b_d, c_q, c_d, d_q, d_d, qs_q, qs_d;
  logic [23:0]   rem1_q, rem1_d, rem2_q, rem2_d, add1_q, add1_d, add2_q, add2_d;
  // control state
  logic [NW-1:0]   cc_q, cc_d, placed_q, placed_d;
  logic [31:0]     len_q, len_d;
  logic [CNTW-1:0] cnt_q, cnt_d, rem_q, rem_d, k_q, k_d;
  logic            vld_q, vld_d, out_valid_q, out_valid_d;
  // working registers
  logic [LW-1:0] adr_q, adr_d;
  logic          dir_q, dir_d;
  logic [CW-1:0] s_q, s_d, pb_q, pb_d, pc_q, pc_d;
  logic [CW-1:0] i_q, i_d, j_q, j_d, lo_q, lo_d, hi_q, hi_d, tmp_q, tmp_d;
  logic [1:0]    st_q, st_d;
  logic [CW-1:0] at_q, at_d, of_q, of_d;
  out_item_t     out_q, out_d;

  // RAM ports
  logic          ord_we, ord_re, slt_we, slt_re, log_we, log_re;
  logic [CW-1:0] ord_waddr, ord_raddr, ord_wdata, ord_rdata;
  logic [CW-1:0] slt_waddr, slt_raddr, slt_wdata, slt_rdata;
  logic [LW-1:0] log_waddr, log_raddr;
  logic [LEW-1:0] log_wdata, log_rdata;

  // log entry fields
  logic [CW-1:0] lg_from, lg_to, lg_low, lg_high;
  logic [NW-1:0] lg_sum;
  logic [31:0]   lg_old;
  assign lg_old  = log_rdata[31:0];
  assign lg_high = log_rdata[OFS_HIGH +: CW];
  assign lg_low  = log_rdata[OFS_LOW  +: CW];
  assign lg_sum  = log_rdata[OFS_SUM  +: NW];
  assign lg_to   = log_rdata[OFS_TO   +: CW];
  assign lg_from = log_rdata[OFS_FROM +: CW];

  // flip bookkeeping
  logic          flip_match, cnt_nz;
  logic [CW-1:0] new_low, new_high;
  logic [31:0]   flip_len, add_inc;
  assign cnt_nz     = (cnt_q != '0);
  assign flip_match = cnt_nz && (lg_from == pb_q) && (lg_to == pc_q);
  assign new_low    = (cnt_nz && !(lg_low > pb_q)) ? lg_low : pb_q;
  assign new_high   = (cnt_nz && !(lg_high < pc_q)) ? lg_high : pc_q;
  assign flip_len   = len_q + 32'(add1_q) + 32'(add2_q) - 32'(rem1_q) - 32'(rem2_q);
  assign add_inc    = ((placed_q != '0) ? 32'(add1_q) : 32'd0)
                    + ((placed_q + 1'b1 == cc_q) ? 32'(add2_q) : 32'd0);

  // status to controller
  assign stat_o.func     = func_q;
  assign stat_o.cnt_zero = !cnt_nz;
  assign stat_o.cnt_full = (32'(cnt_q) >= 32'(LOG_DEPTH));
  assign stat_o.map_done = (rem_q == '0) && !vld_q;
  assign stat_o.pc_lt_pb = (pc_q < pb_q);
  assign stat_o.k_eq_cnt = (k_q == cnt_q);
  assign stat_o.i_lt_j   = (i_q < j_q);
  assign stat_o.lo_gt_hi = (lo_q > hi_q);
  assign stat_o.i_eq_hi  = (i_q == hi_q);
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    logic [31:0] cv;
    func_d = func_q; a_d = a_q; b_d = b_q; c_d = c_q; d_d = d_q; qs_d = qs_q;
    rem1_d = rem1_q; rem2_d = rem2_q; add1_d = add1_q; add2_d = add2_q;
    cc_d = cc_q; placed_d = placed_q; len_d = len_q; cnt_d = cnt_q;
    rem_d = rem_q; k_d = k_q; vld_d = vld_q; adr_d = adr_q; dir_d = dir_q;
    s_d = s_q; pb_d = pb_q; pc_d = pc_q; i_d = i_q; j_d = j_q;
    lo_d = lo_q; hi_d = hi_q; tmp_d = tmp_q; st_d = st_q; at_d = at_q; of_d = of_q;
    out_d = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    ord_we = 1'b0; ord_waddr = i_q; ord_wdata = tmp_q; ord_re = 1'b0; ord_raddr = i_q;
    slt_we = 1'b0; slt_waddr = a_q; slt_wdata = i_q; slt_re = 1'b0; slt_raddr = a_q;
    log_we = 1'b0; log_waddr = LW'(cnt_q); log_re = 1'b0; log_raddr = adr_q;
    log_wdata = {pb_q, pc_q, NW'(pb_q) + NW'(pc_q), new_low, new_high, len_q};

    // city count register, clamped to 3 .. MAX_CITIES
    cv = 32'(cfg_wdata_i);
    if (cv < 32'd3) cv = 32'd3;
    if (cv > 32'(MAX_CITIES)) cv = 32'(MAX_CITIES);
    if (cfg_we_i) cc_d = NW'(cv);

    case (cmd_i.op)
      OP_ACCEPT: begin
        func_d = in_item_i.func;
        a_d    = wrap_city(in_item_i.city_a);
        b_d    = wrap_city(in_item_i.city_b);
        c_d    = wrap_city(in_item_i.city_c);
        d_d    = wrap_city(in_item_i.city_d);
        qs_d   = wrap_city(in_item_i.query_slot);
        rem1_d = in_item_i.cost_removed_one;
        rem2_d = in_item_i.cost_removed_two;
        add1_d = in_item_i.cost_added_one;
        add2_d = in_item_i.cost_added_two;
        st_d = STAT_DONE; at_d = '0; of_d = '0;
      end
      OP_ADD: begin
        if ((placed_q < cc_q) && (placed_q < NW'(MAX_CITIES))) begin
          slt_we = 1'b1; slt_waddr = a_q; slt_wdata = placed_q[CW-1:0];
          ord_we = 1'b1; ord_waddr = placed_q[CW-1:0]; ord_wdata = a_q;
          len_d = len_q + add_inc;
          placed_d = placed_q + 1'b1;
        end
      end
      OP_SLOT_RD: begin
        slt_re = 1'b1;
        case (cmd_i.city)
          CITY_A:  slt_raddr = a_q;
          CITY_B:  slt_raddr = b_q;
          CITY_C:  slt_raddr = c_q;
          default: slt_raddr = d_q;
        endcase
      end
      OP_MAP_FWD: begin
        s_d = slt_rdata; rem_d = cnt_q; adr_d = '0; dir_d = 1'b0; vld_d = 1'b0;
      end
      OP_MAP_BWD: begin
        s_d = qs_q; rem_d = cnt_q; adr_d = LW'(cnt_q - 1'b1); dir_d = 1'b1; vld_d = 1'b0;
      end
      OP_MAP_RUN: begin
        // apply the entry read last cycle, issue the next read
        if (vld_q && (s_q >= lg_from) && (s_q <= lg_to)) s_d = CW'(lg_sum - NW'(s_q));
        if (rem_q != '0) begin
          log_re = 1'b1; log_raddr = adr_q;
          adr_d = dir_q ? adr_q - 1'b1 : adr_q + 1'b1;
          rem_d = rem_q - 1'b1;
          vld_d = 1'b1;
        end else begin
          vld_d = 1'b0;
        end
      end
      OP_SAVE: begin
        if (cmd_i.dst_pc) pc_d = s_q;
        else pb_d = s_q;
      end
      OP_TOP_RD: begin
        log_re = 1'b1; log_raddr = LW'(cnt_q - 1'b1);
      end
      OP_FLIP_END: begin
        if (flip_match) begin
          cnt_d = cnt_q - 1'b1; len_d = lg_old; st_d = STAT_CANCEL;
        end else begin
          log_we = 1'b1; log_waddr = LW'(cnt_q);
          len_d = flip_len; cnt_d = cnt_q + 1'b1;
        end
      end
      OP_REM_EMPTY: st_d = STAT_EMPTY;
      OP_POP: begin
        cnt_d = cnt_q - 1'b1; len_d = lg_old;
      end
      OP_ORDER_RD: begin
        ord_re = 1'b1; ord_raddr = s_q;
      end
      OP_QUERY_AT: at_d = ord_rdata;
      OP_QUERY_OF: of_d = s_q;
      // commit: bounds of the touched range come from the newest entry
      OP_C_LASTW: begin
        lo_d = lg_low; hi_d = lg_high; k_d = '0;
      end
      OP_C_ENT_RD: begin
        log_re = 1'b1; log_raddr = LW'(k_q);
      end
      OP_C_ENTW: begin
        i_d = lg_from; j_d = lg_to; k_d = k_q + 1'b1;
      end
      OP_C_SW0: begin
        ord_re = 1'b1; ord_raddr = i_q;
      end
      OP_C_SW1: begin
        tmp_d = ord_rdata; ord_re = 1'b1; ord_raddr = j_q;
      end
      OP_C_SW2: begin
        ord_we = 1'b1; ord_waddr = i_q; ord_wdata = ord_rdata;
      end
      OP_C_SW3: begin
        ord_we = 1'b1; ord_waddr = j_q; ord_wdata = tmp_q;
        i_d = i_q + 1'b1; j_d = j_q - 1'b1;
      end
      OP_C_SLINIT: i_d = lo_q;
      OP_C_SLRD: begin
        ord_re = 1'b1; ord_raddr = i_q;
      end
      OP_C_SLWR: begin
        slt_we = 1'b1; slt_waddr = ord_rdata; slt_wdata = i_q; i_d = i_q + 1'b1;
      end
      OP_C_CLEAR: cnt_d = '0;
      OP_RESP: begin
        out_valid_d = 1'b1;
        out_d.status        = st_q;
        out_d.tour_length   = len_q;
        out_d.city_at_slot  = 10'(at_q);
        out_d.slot_of_city  = 10'(of_q);
        out_d.pending_flips = 7'(cnt_q);
        out_d.cities_placed = 11'(placed_q);
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cc_q        <= NW'(CC_RST);
      placed_q    <= '0;
      len_q       <= '0;
      cnt_q       <= '0;
      rem_q       <= '0;
      vld_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cc_q        <= cc_d;
      placed_q    <= placed_d;
      len_q       <= len_d;
      cnt_q       <= cnt_d;
      rem_q       <= rem_d;
      vld_q       <= vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    func_q <= func_d; a_q <= a_d; b_q <= b_d; c_q <= c_d; d_q <= d_d; qs_q <= qs_d;
    rem1_q <= rem1_d; rem2_q <= rem2_d; add1_q <= add1_d; add2_q <= add2_d;
    k_q <= k_d; adr_q <= adr_d; dir_q <= dir_d; s_q <= s_d; pb_q <= pb_d; pc_q <= pc_d;
    i_q <= i_d; j_q <= j_d; lo_q <= lo_d; hi_q <= hi_d; tmp_q <= tmp_d;
    st_q <= st_d; at_q <= at_d; of_q <= of_d; out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // city at each real slot
  lzt_ram #(.WIDTH(CW), .DEPTH(MAX_CITIES)) u_order (
    .clk_i, .we_i(ord_we), .waddr_i(ord_waddr), .wdata_i(ord_wdata),
    .re_i(ord_re), .raddr_i(ord_raddr), .rdata_o(ord_rdata)
  );

  // real slot of each city
  lzt_ram #(.WIDTH(CW), .DEPTH(MAX_CITIES)) u_slot (
    .clk_i, .we_i(slt_we), .waddr_i(slt_waddr), .wdata_i(slt_wdata),
    .re_i(slt_re), .raddr_i(slt_raddr), .rdata_o(slt_rdata)
  );

  // reversal log
  lzt_ram #(.WIDTH(LEW), .DEPTH(LOG_DEPTH)) u_log (
    .clk_i, .we_i(log_we), .waddr_i(log_waddr), .wdata_i(log_wdata),
    .re_i(log_re), .raddr_i(log_raddr), .rdata_o(log_rdata)
  );

endmodule

// File: design/lzt_ctrl.sv
// Controller of the lazy 2-opt tour: sequences datapath micro-ops per item.
// Depends on lzt_pkg.
module lzt_ctrl import lzt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;
  logic [1:0]  ph_q, ph_d;
  logic        ret_q, ret_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ph_q    <= '0;
      ret_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      ph_q    <= ph_d;
      ret_q   <= ret_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    ph_d       = ph_q;
    ret_d      = ret_q;
    in_stall_o = 1'b1;
    cmd_o      = '{op: OP_NONE, city: CITY_A, dst_pc: 1'b0};
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.op = OP_ACCEPT;
          state_d  = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (stat_i.func)
          FUNC_ADD: begin
            cmd_o.op = OP_ADD;
            state_d  = ST_RESP;
          end
          FUNC_FLIP: begin
            ph_d = 2'd0;
            if (stat_i.cnt_full) begin
              ret_d   = 1'b1;
              state_d = ST_C_LAST;
            end else begin
              state_d = ST_F_RD;
            end
          end
          FUNC_REMOVE: begin
            if (stat_i.cnt_zero) begin
              cmd_o.op = OP_REM_EMPTY;
              state_d  = ST_RESP;
            end else begin
              cmd_o.op = OP_TOP_RD;
              state_d  = ST_REM_POP;
            end
          end
          FUNC_PERM: begin
            ret_d   = 1'b0;
            state_d = stat_i.cnt_zero ? ST_RESP : ST_C_LAST;
          end
          FUNC_QUERY: state_d = ST_Q_MAPQ;
          default:    state_d = ST_RESP;
        endcase
      end
      // flip lookups: phase 0 b, 1 c, 2 a, 3 d
      ST_F_RD: begin
        cmd_o.op = OP_SLOT_RD;
        case (ph_q)
          2'd0:    cmd_o.city = CITY_B;
          2'd1:    cmd_o.city = CITY_C;
          2'd2:    cmd_o.city = CITY_A;
          default: cmd_o.city = CITY_D;
        endcase
        state_d = ST_F_MAP;
      end
      ST_F_MAP: begin
        cmd_o.op = OP_MAP_FWD;
        state_d  = ST_F_RUN;
      end
      ST_F_RUN: begin
        if (stat_i.map_done) begin
          cmd_o.op     = OP_SAVE;
          cmd_o.dst_pc = (ph_q == 2'd1) || (ph_q == 2'd2);
          case (ph_q)
            2'd0: begin
              ph_d = 2'd1; state_d = ST_F_RD;
            end
            2'd1: state_d = ST_F_CHK;
            2'd2: begin
              ph_d = 2'd3; state_d = ST_F_RD;
            end
            default: state_d = ST_F_TOP;
          endcase
        end else begin
          cmd_o.op = OP_MAP_RUN;
        end
      end
      ST_F_CHK: begin
        if (stat_i.pc_lt_pb) begin
          ph_d = 2'd2; state_d = ST_F_RD;
        end else begin
          state_d = ST_F_TOP;
        end
      end
      ST_F_TOP: begin
        cmd_o.op = OP_TOP_RD;
        state_d  = ST_F_END;
      end
      ST_F_END: begin
        cmd_o.op = OP_FLIP_END;
        state_d  = ST_RESP;
      end
      ST_REM_POP: begin
        cmd_o.op = OP_POP;
        state_d  = ST_RESP;
      end
      // query: slot to city, then city to slot
      ST_Q_MAPQ: begin
        cmd_o.op = OP_MAP_BWD;
        state_d  = ST_Q_RUNQ;
      end
      ST_Q_RUNQ: begin
        if (stat_i.map_done) begin
          cmd_o.op = OP_ORDER_RD;
          state_d  = ST_Q_AT;
        end else begin
          cmd_o.op = OP_MAP_RUN;
        end
      end
      ST_Q_AT: begin
        cmd_o.op = OP_QUERY_AT;
        state_d  = ST_Q_RDA;
      end
      ST_Q_RDA: begin
        cmd_o.op   = OP_SLOT_RD;
        cmd_o.city = CITY_A;
        state_d    = ST_Q_MAPA;
      end
      ST_Q_MAPA: begin
        cmd_o.op = OP_MAP_FWD;
        state_d  = ST_Q_RUNA;
      end
      ST_Q_RUNA: begin
        if (stat_i.map_done) begin
          cmd_o.op = OP_QUERY_OF;
          state_d  = ST_RESP;
        end else begin
          cmd_o.op = OP_MAP_RUN;
        end
      end
      // commit: reverse each logged range, then rewrite slots
      ST_C_LAST: begin
        cmd_o.op = OP_TOP_RD;
        state_d  = ST_C_LASTW;
      end
      ST_C_LASTW: begin
        cmd_o.op = OP_C_LASTW;
        state_d  = ST_C_ENT;
      end
      ST_C_ENT: begin
        if (stat_i.k_eq_cnt) begin
          state_d = ST_C_SLINIT;
        end else begin
          cmd_o.op = OP_C_ENT_RD;
          state_d  = ST_C_ENTW;
        end
      end
      ST_C_ENTW: begin
        cmd_o.op = OP_C_ENTW;
        state_d  = ST_C_SWCHK;
      end
      ST_C_SWCHK: begin
        if (stat_i.i_lt_j) begin
          cmd_o.op = OP_C_SW0;
          state_d  = ST_C_SW1;
        end else begin
          state_d = ST_C_ENT;
        end
      end
      ST_C_SW1: begin
        cmd_o.op = OP_C_SW1;
        state_d  = ST_C_SW2;
      end
      ST_C_SW2: begin
        cmd_o.op = OP_C_SW2;
        state_d  = ST_C_SW3;
      end
      ST_C_SW3: begin
        cmd_o.op = OP_C_SW3;
        state_d  = ST_C_SWCHK;
      end
      ST_C_SLINIT: begin
        cmd_o.op = OP_C_SLINIT;
        state_d  = ST_C_SLRD;
      end
      ST_C_SLRD: begin
        if (stat_i.lo_gt_hi) begin
          state_d = ST_C_DONE;
        end else begin
          cmd_o.op = OP_C_SLRD;
          state_d  = ST_C_SLWR;
        end
      end
      ST_C_SLWR: begin
        cmd_o.op = OP_C_SLWR;
        state_d  = stat_i.i_eq_hi ? ST_C_DONE : ST_C_SLRD;
      end
      ST_C_DONE: begin
        cmd_o.op = OP_C_CLEAR;
        if (ret_q) begin
          ph_d = 2'd0; state_d = ST_F_RD;
        end else begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_RESP;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// File: design/lzt_checker.sv
// Port checker for the lazy 2-opt tour, bound to the top level.
// Depends on lzt_pkg and lazy_two_opt_tour_flip_log_assert.svh.
`include "lazy_two_opt_tour_flip_log_assert.svh"

module lzt_checker import lzt_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input in_item_t    in_item_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input out_item_t   out_item_o,
  input logic        cfg_we_i,
  input logic [10:0] cfg_wdata_i
);

  // a stalled result stays
  `LZT_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o, "result dropped")
  `LZT_ASSERT(a_out_stable, out_valid_o && out_stall_i |=> $stable(out_item_o), "result changed")
  // one item at a time: accepting an item blocks the next cycle
  `LZT_ASSERT(a_busy, in_valid_i && !in_stall_o |=> in_stall_o, "second item taken")
  // empty log report implies no pending flips
  `LZT_ASSERT(a_empty, out_valid_o && (out_item_o.status == STAT_EMPTY) |-> (out_item_o.pending_flips == 7'd0), "empty with flips")
  // no result during reset
  `LZT_ASSERT_ALWAYS(a_rst, !rst_ni |-> !out_valid_o, "result in reset")

endmodule

bind lazy_two_opt_tour_flip_log lzt_checker u_chk (.*);

// File: test/tb_lazy_two_opt_tour_flip_log.sv
// Self-checking testbench for the lazy 2-opt tour block: a directed table, then random
// tours, flips, queries, undo and commits, checked against a behavioral tour model.
// Depends on lzt_pkg and lazy_two_opt_tour_flip_log.
`timescale 1ns / 100ps

module tb_lazy_two_opt_tour_flip_log;
  import lzt_pkg::*;

  localparam int NCITY     = 1024;
  localparam int NLOG      = 64;
  localparam int IDLE_MAX  = 1000000;
  localparam int N_RAND_A  = 900;
  localparam int N_RAND_B  = 950;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_item_t    in_item_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_item_o;
  logic        cfg_we_i = 1'b0;
  logic [10:0] cfg_wdata_i = '0;

  lazy_two_opt_tour_flip_log DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_item_i,
    .out_valid_o, .out_stall_i, .out_item_o, .cfg_we_i, .cfg_wdata_i
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Tour model state
  logic [9:0]  tour_city [NCITY];
  logic [9:0]  tour_slot [NCITY];
  int          rev_from [NLOG];
  int          rev_to [NLOG];
  int          rev_sum [NLOG];
  int          rev_low [NLOG];
  int          rev_high [NLOG];
  logic [31:0] rev_len [NLOG];
  int          rev_cnt = 0;
  int          n_placed = 0;
  logic [31:0] tour_len = '0;
  int          city_limit = NCITY;

  out_item_t   pending_results [$];
  logic [9:0]  placed_ids [$];
  int          fail_cnt = 0;
  int          burst_left = 0;
  bit          hold_req = 1'b0;

  // Map a real slot through the reversals, oldest first
  function automatic int to_virtual(int s);
    for (int k = 0; k < rev_cnt; k++)
      if (s >= rev_from[k] && s <= rev_to[k]) s = rev_sum[k] - s;
    return s;
  endfunction

  // Map a virtual slot back, newest first
  function automatic int to_real(int s);
    for (int k = rev_cnt - 1; k >= 0; k--)
      if (s >= rev_from[k] && s <= rev_to[k]) s = rev_sum[k] - s;
    return s;
  endfunction

  // Apply all logged reversals to the tour and rewrite slots
  function automatic void apply_reversals();
    int lo, hi, i, j;
    logic [9:0] t;
    if (rev_cnt == 0) return;
    lo = rev_low[rev_cnt-1];
    hi = rev_high[rev_cnt-1];
    for (int k = 0; k < rev_cnt; k++) begin
      i = rev_from[k];
      j = rev_to[k];
      while (i < j) begin
        t = tour_city[i]; tour_city[i] = tour_city[j]; tour_city[j] = t;
        i++; j--;
      end
    end
    for (i = lo; i <= hi && i < NCITY; i++) tour_slot[tour_city[i]] = i[9:0];
    rev_cnt = 0;
  endfunction

  // Expected result of one item; updates the tour model
  function automatic out_item_t tour_step(in_item_t it);
    out_item_t r;
    int pb, pc, n;
    r = '0;
    r.status = STAT_DONE;
    case (it.func)
      FUNC_ADD: begin
        if (n_placed < city_limit && n_placed < NCITY) begin
          tour_slot[it.city_a] = n_placed[9:0];
          tour_city[n_placed] = it.city_a;
          placed_ids.push_back(it.city_a);
          if (n_placed > 0) tour_len += 32'(it.cost_added_one);
          n_placed++;
          if (n_placed == city_limit) tour_len += 32'(it.cost_added_two);
        end
      end
      FUNC_FLIP: begin
        if (rev_cnt >= NLOG) apply_reversals();
        pb = to_virtual(tour_slot[it.city_b]);
        pc = to_virtual(tour_slot[it.city_c]);
        if (pc < pb) begin
          pc = to_virtual(tour_slot[it.city_a]);
          pb = to_virtual(tour_slot[it.city_d]);
        end
        n = rev_cnt;
        if (n > 0 && rev_from[n-1] == pb && rev_to[n-1] == pc) begin
          rev_cnt = n - 1;
          tour_len = rev_len[n-1];
          r.status = STAT_CANCEL;
        end else begin
          rev_low[n]  = (n > 0 && rev_low[n-1] < pb) ? rev_low[n-1] : pb;
          rev_high[n] = (n > 0 && rev_high[n-1] > pc) ? rev_high[n-1] : pc;
          rev_from[n] = pb;
          rev_to[n]   = pc;
          rev_sum[n]  = pb + pc;
          rev_len[n]  = tour_len;
          tour_len = tour_len - it.cost_removed_one - it.cost_removed_two
                     + it.cost_added_one + it.cost_added_two;
          rev_cnt = n + 1;
        end
      end
      FUNC_REMOVE: begin
        if (rev_cnt == 0) r.status = STAT_EMPTY;
        else begin
          rev_cnt--;
          tour_len = rev_len[rev_cnt];
        end
      end
      FUNC_PERM: apply_reversals();
      FUNC_QUERY: begin
        r.city_at_slot = tour_city[to_real(it.query_slot)];
        r.slot_of_city = 10'(to_virtual(tour_slot[it.city_a]));
      end
      default: ;
    endcase
    r.tour_length   = tour_len;
    r.pending_flips = 7'(rev_cnt);
    r.cities_placed = 11'(n_placed);
    return r;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", field, got, want, $realtime);
    fail_cnt++;
  endtask

  // Offer one item, wait for acceptance, then record its expected result
  task automatic send_item(in_item_t it, bit typed = 1'b0, out_item_t want = '0);
    out_item_t r;
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    r = tour_step(it);
    pending_results.push_back(typed ? want : r);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 25);
    end else begin
      burst_left--;
    end
  endtask

  // Drop valid and wait for every expected result
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_city_count(logic [10:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    city_limit = (v < 3) ? 3 : (v > NCITY) ? NCITY : int'(v);
    @(posedge clk_i);
  endtask

  function automatic logic [9:0] pick_city();
    return placed_ids[$urandom_range(0, placed_ids.size() - 1)];
  endfunction

  // Random item; well-formed flips and queries dominate
  function automatic in_item_t random_item(int add_pct);
    in_item_t it;
    int roll;
    it = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    roll = $urandom_range(0, 99);
    if (roll < add_pct) it.func = FUNC_ADD;
    else if (roll < 55) it.func = FUNC_FLIP;
    else if (roll < 75) it.func = FUNC_QUERY;
    else if (roll < 87) it.func = FUNC_REMOVE;
    else if (roll < 95) it.func = FUNC_PERM;
    else it.func = 3'($urandom_range(5, 7));
    if (it.func == FUNC_FLIP || it.func == FUNC_QUERY) begin
      it.city_a = pick_city();
      it.city_b = pick_city();
      it.city_c = pick_city();
      it.city_d = pick_city();
      it.query_slot = 10'($urandom_range(0, n_placed - 1));
    end
    if ($urandom_range(0, 7) == 0) begin
      it.cost_removed_one = '1;
      it.cost_added_two = '1;
    end
    return it;
  endfunction

  // Directed table
  typedef struct {
    in_item_t  it;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  dir_row_t dir_rows [$];

  function automatic void add_row(logic [2:0] f, logic [9:0] a, logic [9:0] b, logic [9:0] c,
                                  logic [9:0] d, logic [9:0] q, logic [23:0] r1,
                                  logic [23:0] r2, logic [23:0] a1, logic [23:0] a2,
                                  bit typed = 1'b0, out_item_t want = '0);
    dir_row_t row;
    row.it = '{f, a, b, c, d, q, r1, r2, a1, a2};
    row.typed = typed;
    row.want = want;
    dir_rows.push_back(row);
  endfunction

  function automatic void build_table();
    // empty log and unused codes right after reset
    add_row(FUNC_REMOVE, '1, '1, '1, '1, '1, '1, '1, '1, '1, 1'b1,
            '{STAT_EMPTY, 32'd0, 10'd0, 10'd0, 7'd0, 11'd0});
    add_row(FUNC_PERM, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1, '0);
    add_row(3'd7, '1, '1, '1, '1, '1, '1, '1, '1, '1, 1'b1, '0);
    // three-city tour: first add costs nothing, last closes the loop
    add_row(FUNC_ADD, 10'd1023, 0, 0, 0, 0, 0, 0, '1, '1, 1'b1,
            '{STAT_DONE, 32'd0, 10'd0, 10'd0, 7'd0, 11'd1});
    add_row(FUNC_ADD, 10'd0, 0, 0, 0, 0, 0, 0, '1, '1, 1'b1,
            '{STAT_DONE, 32'hFFFFFF, 10'd0, 10'd0, 7'd0, 11'd2});
    add_row(FUNC_ADD, 10'd5, 0, 0, 0, 0, 0, 0, 24'd1, '1, 1'b1,
            '{STAT_DONE, 32'h1FFFFFF, 10'd0, 10'd0, 7'd0, 11'd3});
    // tour full: ignored
    add_row(FUNC_ADD, 10'd7, 0, 0, 0, 0, '1, '1, '1, '1, 1'b1,
            '{STAT_DONE, 32'h1FFFFFF, 10'd0, 10'd0, 7'd0, 11'd3});
    add_row(FUNC_QUERY, 10'd5, 0, 0, 0, 10'd0, 0, 0, 0, 0);
    add_row(FUNC_QUERY, 10'd1023, 0, 0, 0, 10'd2, 0, 0, 0, 0);
    // flip, then the same flip again cancels it
    add_row(FUNC_FLIP, 10'd1023, 10'd0, 10'd5, 10'd1023, 0, '1, '1, 0, 0);
    add_row(FUNC_FLIP, 10'd1023, 10'd0, 10'd5, 10'd1023, 0, 0, 0, 0, 0);
    // reversed range normalised via a and d
    add_row(FUNC_FLIP, 10'd0, 10'd5, 10'd0, 10'd1023, 0, '1, '1, 0, 0);
    add_row(FUNC_QUERY, 10'd0, 0, 0, 0, 10'd1, 0, 0, 0, 0);
    add_row(FUNC_FLIP, 10'd5, 10'd1023, 10'd1023, 10'd0, 0, '1, 0, '1, '1);
    add_row(FUNC_REMOVE, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(FUNC_FLIP, 10'd1023, 10'd0, 10'd0, 10'd5, 0, 0, 0, '1, '1);
    add_row(FUNC_PERM, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(FUNC_QUERY, 10'd0, 0, 0, 0, 10'd0, 0, 0, 0, 0);
    add_row(FUNC_QUERY, 10'd5, 0, 0, 0, 10'd2, 0, 0, 0, 0);
    add_row(3'd5, '1, '1, '1, '1, '1, '1, '1, '1, '1);
    add_row(3'd6, 0, 0, 0, 0, 0, 0, 0, 0, 0);
  endfunction

  // Result checker
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", out_item_o.tour_length, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_item_o.status !== want.status)
          report_mismatch("status", out_item_o.status, want.status);
        if (out_item_o.tour_length !== want.tour_length)
          report_mismatch("tour_length", out_item_o.tour_length, want.tour_length);
        if (out_item_o.city_at_slot !== want.city_at_slot)
          report_mismatch("city_at_slot", out_item_o.city_at_slot, want.city_at_slot);
        if (out_item_o.slot_of_city !== want.slot_of_city)
          report_mismatch("slot_of_city", out_item_o.slot_of_city, want.slot_of_city);
        if (out_item_o.pending_flips !== want.pending_flips)
          report_mismatch("pending_flips", out_item_o.pending_flips, want.pending_flips);
        if (out_item_o.cities_placed !== want.cities_placed)
          report_mismatch("cities_placed", out_item_o.cities_placed, want.cities_placed);
      end
    end
  end

  // Receiver stall pattern, with one long hold on request
  initial begin
    int mode;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (400) @(posedge clk_i);
      end
      mode = $urandom_range(0, 3);
      out_stall_i <= (mode == 0) ? 1'b1 : (mode == 1) ? 1'($urandom) : 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  // Watchdog on cycles without any handshake
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle = 0;
      else idle++;
      if (idle >= IDLE_MAX) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    build_table();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // clamps to the minimum tour size
    write_city_count(11'd0);
    foreach (dir_rows[i]) send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);
    drain();

    // small tour: most of the flip and commit traffic
    write_city_count(11'd16);
    while (n_placed < 16) send_item(random_item(100));
    for (int i = 0; i < N_RAND_A; i++) begin
      if (i == 300) begin
        hold_req = 1'b1;
        burst_left = 200;
      end
      if (i == 600) drain();
      send_item(random_item(3));
    end
    drain();

    // clamps to the maximum; the tour grows from here on
    write_city_count(11'h7FF);
    for (int i = 0; i < N_RAND_B; i++) send_item(random_item(12));
    drain();
    write_city_count(11'd1024);
    for (int i = 0; i < 40; i++) send_item(random_item(10));
    drain();

    repeat (50) @(posedge clk_i);
    if (fail_cnt == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
